// ===== hdl/lbsv_pkg.sv =====
`default_nettype none
package lbsv_pkg;

   localparam int LBS_NUM_NODES  = 256;
   localparam int LBS_MAX_JOINTS = 4;
   localparam int LBS_ELEMS      = 12;   // 3x4 row-major, column 3 is translation
   localparam int LBS_NODE_W     = 8;    // stored joint node index
   localparam int LBS_WEIGHT_W   = 24;
   localparam int LBS_COORD_W    = 32;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_JOINT = 2'd1,
      ACT_POINT = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_JOINT,
      ST_RD,
      ST_MUL,
      ST_ACC,
      ST_TSAT,
      ST_WMUL,
      ST_WACC,
      ST_DIV,
      ST_FIN
   } state_type;

   // Saturate a transformed coordinate to signed Q16.16.
   function automatic logic [31:0] sat_coord(input logic signed [50:0] v);
      logic [31:0] r;
      if (v > 51'sd2147483647) begin
         r = 32'h7fff_ffff;
      end else if (v < -51'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/linear_blend_skin_vertex.sv =====
`default_nettype none
// Linear blend skinning of one vertex over up to MAX_JOINTS bone influences.
// Items: action 0 writes one Q16.16 element of a node's 3x4 bone matrix (and
// marks the node valid), action 1 adds a joint (node, weight), action 2 sends
// the point and ends the vertex; only point items return a result. Matrix
// writes and joint items never stall the block. A point with no kept joint
// goes straight to the output stage and passes through with rsp_unskinned
// set. A skinned point walks a sequencer over the matrix memory with a 32x32
// multiplier for the matrix products and a separate weight multiplier: for
// each of the three rows and each kept joint, a valid node takes four
// element reads at one memory port, three MACs, saturate and a weight
// multiply, while an invalid node goes straight to the weight multiply with
// the point coordinate; then comes a bit-serial divide by the weight total.
// The next item is taken as soon as the result is in the output register.
// Matrix valid marks clear at reset; matrix elements never written read as
// garbage and must be loaded before a node is used.
module linear_blend_skin_vertex
   import lbsv_pkg::*;
#(
   parameter int NUM_NODES  = LBS_NUM_NODES,
   parameter int MAX_JOINTS = LBS_MAX_JOINTS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic signed [8:0]  req_node,
   input  wire logic [3:0]  req_slot,
   input  wire logic signed [31:0] req_elem_value,
   input  wire logic [23:0] req_weight,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_point_z,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic             rsp_unskinned
);

   localparam int NIX_W   = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
   localparam int ADDR_W  = $clog2(NUM_NODES * LBS_ELEMS);
   localparam int KW      = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int CW      = $clog2(MAX_JOINTS + 1);
   localparam int TOTAL_W = LBS_WEIGHT_W + ((MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 0);
   localparam int ACC_W   = 57 + ((MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 0);

   state_type state_ff, state_in;

   // joint list
   logic [CW-1:0]         count_ff, count_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [LBS_NODE_W-1:0] nodes_ff [MAX_JOINTS];
   logic [LBS_WEIGHT_W-1:0] weights_ff [MAX_JOINTS];
   logic                  jadd;

   // datapath
   logic signed [31:0] p_ff [3];
   logic signed [31:0] res_ff [3];
   logic               unsk_ff, unsk_in;
   logic [1:0]         r_ff, r_in;
   logic [1:0]         c_ff, c_in;
   logic [KW-1:0]      k_ff, k_in;
   logic signed [63:0] prod_ff;
   logic signed [65:0] s_ff;
   logic signed [31:0] m3_ff;
   logic signed [31:0] t_ff;
   logic signed [56:0] wprod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [31:0] pc;
   logic signed [50:0] tsum;
   logic               div_kick_ff, div_kick_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] out_x_ff, out_y_ff, out_z_ff;
   logic        out_unsk_ff;
   logic        out_load;

   // memory hookup
   logic              accept;
   logic [12:0]       wnode13;
   logic [12:0]       jnode13;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [31:0]       rd_data;
   logic              node_valid;
   logic              jvalid;
   logic              div_start;
   logic              div_done;
   logic [31:0]       div_q;

   assign accept  = req_valid && !req_stall;
   assign wnode13 = {5'b0, req_node[7:0]};
   assign jnode13 = {5'b0, nodes_ff[k_ff]};

   assign wr_en   = accept && (req_action == ACT_WRITE) && !req_node[8]
                    && (wnode13 < 13'(NUM_NODES)) && (req_slot < 4'(LBS_ELEMS));
   assign wr_addr = ADDR_W'(17'(wnode13) * 17'(LBS_ELEMS) + 17'(req_slot));
   assign rd_addr = ADDR_W'(17'(jnode13) * 17'(LBS_ELEMS) + 17'({r_ff, c_ff}));
   assign jvalid  = (jnode13 < 13'(NUM_NODES)) && node_valid;

   assign jadd = accept && (req_action == ACT_JOINT) && !req_node[8]
                 && (req_weight != '0) && (count_ff < CW'(MAX_JOINTS));

   lbsv_matrix_store #(
      .NUM_NODES(NUM_NODES),
      .ADDR_W   (ADDR_W),
      .NIX_W    (NIX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_node  (wnode13[NIX_W-1:0]),
      .wr_data  (req_elem_value),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .chk_node (jnode13[NIX_W-1:0]),
      .chk_valid(node_valid)
   );

   lbsv_divider #(
      .ACC_W  (ACC_W),
      .TOTAL_W(TOTAL_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(acc_ff),
      .divisor (total_ff),
      .done    (div_done),
      .quotient(div_q)
   );

   // point coordinate for the current element
   always_comb begin
      case (c_ff)
         2'd0:    pc = p_ff[0];
         2'd1:    pc = p_ff[1];
         default: pc = p_ff[2];
      endcase
   end

   assign tsum = $signed(s_ff[65:16]) + m3_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      unsk_in      = unsk_ff;
      div_start    = 1'b0;
      out_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      count_in     = count_ff;
      total_in     = total_ff;
      req_stall    = (state_ff != ST_IDLE);
      if (jadd) begin
         count_in = count_ff + CW'(1);
         total_in = total_ff + TOTAL_W'(req_weight);
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action == ACT_POINT)) begin
               r_in = 2'd0;
               k_in = '0;
               if (count_ff == '0) begin
                  unsk_in  = 1'b1;
                  state_in = ST_FIN;
               end else begin
                  unsk_in  = 1'b0;
                  state_in = ST_JOINT;
               end
            end
         end
         ST_JOINT: begin
            c_in     = 2'd0;
            state_in = jvalid ? ST_RD : ST_TSAT;
         end
         ST_RD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = (c_ff == 2'd3) ? ST_TSAT : ST_ACC;
         end
         ST_ACC: begin
            c_in     = c_ff + 2'd1;
            state_in = ST_RD;
         end
         ST_TSAT: begin
            state_in = ST_WMUL;
         end
         ST_WMUL: begin
            state_in = ST_WACC;
         end
         ST_WACC: begin
            if ((CW'(k_ff) + CW'(1)) == count_ff) begin
               state_in = ST_DIV;
            end else begin
               k_in     = k_ff + KW'(1);
               state_in = ST_JOINT;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               k_in = '0;
               if (r_ff == 2'd2) begin
                  state_in = ST_FIN;
               end else begin
                  r_in     = r_ff + 2'd1;
                  state_in = ST_JOINT;
               end
            end
         end
         ST_FIN: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               count_in     = '0;
               total_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // kick the divider the cycle after the last weighted add
      div_kick_in = (state_ff == ST_WACC) && (state_in == ST_DIV);
      if (state_ff == ST_DIV && div_kick_ff) begin
         div_start = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_kick_ff <= 1'b0;
      end else begin
         div_kick_ff <= div_kick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff    <= r_in;
      c_ff    <= c_in;
      k_ff    <= k_in;
      unsk_ff <= unsk_in;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (jadd) begin
         nodes_ff[count_ff[KW-1:0]]   <= req_node[7:0];
         weights_ff[count_ff[KW-1:0]] <= req_weight;
      end
      if (state_ff == ST_IDLE && accept && req_action == ACT_POINT) begin
         p_ff[0]   <= req_point_x;
         p_ff[1]   <= req_point_y;
         p_ff[2]   <= req_point_z;
         res_ff[0] <= req_point_x;
         res_ff[1] <= req_point_y;
         res_ff[2] <= req_point_z;
         acc_ff    <= '0;
      end
      if (state_ff == ST_JOINT) begin
         s_ff <= '0;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= $signed(rd_data) * pc;
         m3_ff   <= $signed(rd_data);
      end
      if (state_ff == ST_ACC) begin
         s_ff <= s_ff + prod_ff;
      end
      if (state_ff == ST_TSAT) begin
         t_ff <= jvalid ? $signed(sat_coord(tsum)) : p_ff[r_ff];
      end
      if (state_ff == ST_WMUL) begin
         wprod_ff <= $signed({1'b0, weights_ff[k_ff]}) * t_ff;
      end
      if (state_ff == ST_WACC) begin
         acc_ff <= acc_ff + wprod_ff;
      end
      if (state_ff == ST_DIV && div_done) begin
         res_ff[r_ff] <= $signed(div_q);
         acc_ff       <= '0;
      end
      if (out_load) begin
         out_x_ff    <= res_ff[0];
         out_y_ff    <= res_ff[1];
         out_z_ff    <= res_ff[2];
         out_unsk_ff <= unsk_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_out_z     = out_z_ff;
   assign rsp_unskinned = out_unsk_ff;

endmodule
`default_nettype wire

// ===== hdl/lbsv_matrix_store.sv =====
`default_nettype none
module lbsv_matrix_store
   import lbsv_pkg::*;
#(
   parameter int NUM_NODES = LBS_NUM_NODES,
   parameter int ADDR_W    = 12,
   parameter int NIX_W     = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [NIX_W-1:0]  wr_node,
   input  wire logic [31:0]       wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]            rd_data,
   input  wire logic [NIX_W-1:0]  chk_node,
   output logic                   chk_valid
);

   localparam int DEPTH = NUM_NODES * LBS_ELEMS;

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;
   logic [NUM_NODES-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // mark a node valid on any element write
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_node] <= 1'b1;
      end
   end

   assign rd_data   = rd_data_ff;
   assign chk_valid = valid_ff[chk_node];

endmodule
`default_nettype wire

// ===== hdl/lbsv_divider.sv =====
`default_nettype none
module lbsv_divider
   import lbsv_pkg::*;
#(
   parameter int ACC_W   = 59,
   parameter int TOTAL_W = 26
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [ACC_W-1:0] dividend,
   input  wire logic [TOTAL_W-1:0]      divisor,
   output logic                         done,
   output logic [31:0]                  quotient
);

   localparam int MAG_W = ACC_W - 1;
   localparam int CNT_W = $clog2(MAG_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [MAG_W-1:0]     mag_ff, mag_in;
   logic [TOTAL_W-1:0]   rem_ff, rem_in;
   logic [TOTAL_W-1:0]   div_ff, div_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [TOTAL_W:0]     rem_sh;
   logic [TOTAL_W:0]     rem_sub;
   logic [ACC_W-1:0]     abs_val;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      abs_val = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
      rem_sh  = {rem_ff, mag_ff[MAG_W-1]};
      rem_sub = rem_sh - {1'b0, div_ff};
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[ACC_W-1];
         mag_in  = abs_val[MAG_W-1:0];
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(MAG_W);
      end else if (busy_ff) begin
         // one quotient bit a cycle, shifted in where the dividend leaves
         if (!rem_sub[TOTAL_W]) begin
            rem_in = rem_sub[TOTAL_W-1:0];
            mag_in = {mag_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[TOTAL_W-1:0];
            mag_in = {mag_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   // apply sign and saturate
   always_comb begin
      if (!neg_ff) begin
         quotient = (mag_ff > MAG_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : mag_ff[31:0];
      end else begin
         quotient = (mag_ff > MAG_W'(33'h0_8000_0000)) ? 32'h8000_0000
                                                       : 32'(-mag_ff[31:0]);
      end
   end

   assign done = done_ff;

endmodule
`default_nettype wire

// ===== hdl/lbsv_checker.sv =====
`default_nettype none
module lbsv_checker
   import lbsv_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_action,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic signed [31:0] rsp_out_x,
   input wire logic        rsp_unskinned
);

   // a stalled item stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_x) && $stable(rsp_unskinned))
      else $error("rsp payload changed while stalled");

   // an accepted point always makes the block busy in the next cycle
   a_point_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == ACT_POINT |=> req_stall)
      else $error("point item did not hold off the next item");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp item after reset");

endmodule

bind linear_blend_skin_vertex lbsv_checker u_lbsv_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
   import lbsv_pkg::*;

   // Clock, reset and the two channels of the block.
   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   action_type req_action;
   logic signed [8:0]  req_node;
   logic [3:0]         req_slot;
   logic signed [31:0] req_elem_value;
   logic [23:0]        req_weight;
   logic signed [31:0] req_point_x;
   logic signed [31:0] req_point_y;
   logic signed [31:0] req_point_z;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic               rsp_unskinned;

   linear_blend_skin_vertex dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_node       (req_node),
      .req_slot       (req_slot),
      .req_elem_value (req_elem_value),
      .req_weight     (req_weight),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_unskinned  (rsp_unskinned)
   );

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        unskinned;
   } skinned_vertex_type;

   // Expected skinned vertices, oldest first.
   skinned_vertex_type pending_vertices[$];

   // Shadow of the block's bone table and joint list.
   logic [31:0] bone_elems[LBS_NUM_NODES*LBS_ELEMS];
   bit          bone_valid[LBS_NUM_NODES];
   int          joint_cnt;
   logic [7:0]  joint_node_q[LBS_MAX_JOINTS];
   logic [23:0] joint_weight_q[LBS_MAX_JOINTS];
   logic [25:0] weight_sum;

   int send_idle_pct;
   int recv_idle_pct;
   int mismatches;

   // Generate the 10 ns clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // End the run if the block hangs.
   initial begin
      #50_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   // One row of a bone matrix applied to the point: floor of the exact
   // product sum over 2^16, plus translation, then clip.
   function automatic longint bone_row(input int n, input int r,
                                       input longint px, input longint py,
                                       input longint pz);
      longint hi, lo, prod, m3;
      longint p[3];
      int base;
      p[0] = px; p[1] = py; p[2] = pz;
      base = n * LBS_ELEMS + r * 4;
      hi = 0;
      lo = 0;
      for (int c = 0; c < 3; c++) begin
         prod = longint'($signed(bone_elems[base + c])) * p[c];
         hi += prod >>> 16;
         lo += prod & 64'hffff;
      end
      hi += lo >>> 16;
      m3 = longint'($signed(bone_elems[base + 3]));
      return longint'($signed(clip32(hi + m3)));
   endfunction

   // Advance the shadow state by one accepted item; queue a vertex on points.
   task automatic skin_predict();
      skinned_vertex_type v;
      longint p[3], acc, t;
      logic [31:0] res[3];
      int n;
      case (req_action)
         ACT_WRITE: begin
            if (req_node >= 0 && req_slot < LBS_ELEMS) begin
               bone_elems[int'(req_node) * LBS_ELEMS + req_slot] = req_elem_value;
               bone_valid[req_node] = 1'b1;
            end
         end
         ACT_JOINT: begin
            if (req_node >= 0 && req_weight != 0 && joint_cnt < LBS_MAX_JOINTS) begin
               joint_node_q[joint_cnt] = req_node[7:0];
               joint_weight_q[joint_cnt] = req_weight;
               weight_sum += req_weight;
               joint_cnt++;
            end
         end
         ACT_POINT: begin
            p[0] = req_point_x; p[1] = req_point_y; p[2] = req_point_z;
            if (joint_cnt == 0 || weight_sum == 0) begin
               for (int r = 0; r < 3; r++) res[r] = p[r][31:0];
               v.unskinned = 1'b1;
            end else begin
               for (int r = 0; r < 3; r++) begin
                  acc = 0;
                  for (int k = 0; k < joint_cnt; k++) begin
                     n = joint_node_q[k];
                     if (bone_valid[n]) t = bone_row(n, r, p[0], p[1], p[2]);
                     else t = p[r];
                     acc += longint'(joint_weight_q[k]) * t;
                  end
                  res[r] = clip32(acc / longint'(weight_sum));
               end
               v.unskinned = 1'b0;
            end
            v.x = res[0]; v.y = res[1]; v.z = res[2];
            pending_vertices.insert(pending_vertices.size(), v);
            joint_cnt = 0;
            weight_sum = 0;
            for (int k = 0; k < LBS_MAX_JOINTS; k++) begin
               joint_node_q[k] = '0;
               joint_weight_q[k] = '0;
            end
         end
         default: ;
      endcase
   endtask

   // Send one item: idle at random, hold the payload while stalled.
   task automatic send_item(input action_type act, input int node, input int slot,
                            input logic [31:0] val, input logic [23:0] w,
                            input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_action     = act;
      req_node       = node[8:0];
      req_slot       = slot[3:0];
      req_elem_value = val;
      req_weight     = w;
      req_point_x    = px;
      req_point_y    = py;
      req_point_z    = pz;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
         if (taken) skin_predict();
         @(negedge clock);
      end
   endtask

   // Random 32-bit value with weight on extremes and small magnitudes.
   function automatic logic [31:0] pick32();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return $urandom_range(262143) - 131072;
      endcase
   endfunction

   function automatic logic [23:0] pick_weight();
      case ($urandom_range(2))
         0: return $urandom_range(24'hffffff, 1);
         1: return $urandom_range(24'h1ffff, 1);
         default: return $urandom_range(1) ? 24'hffffff : 24'd1;
      endcase
   endfunction

   // Load all twelve elements of a node so it is never read half-written.
   task automatic load_bone(input int n, input bit identity);
      logic [31:0] e;
      for (int s = 0; s < LBS_ELEMS; s++) begin
         if (identity) e = (s % 5 == 0) ? 32'h0001_0000 : 32'h0;
         else e = pick32();
         send_item(ACT_WRITE, n, s, e, $urandom, $urandom, $urandom, $urandom);
      end
   endtask

   task automatic add_joint(input int n, input logic [23:0] w);
      send_item(ACT_JOINT, n, $urandom, $urandom, w, $urandom, $urandom, $urandom);
   endtask

   task automatic end_vertex(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
      send_item(ACT_POINT, $urandom, $urandom, $urandom, $urandom, x, y, z);
   endtask

   task automatic drain_vertices();
      req_valid = 1'b0;
      while (pending_vertices.size() != 0) @(negedge clock);
   endtask

   // Receiver: stall at random on the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Compare each accepted vertex with the oldest expectation.
   always @(posedge clock) begin
      skinned_vertex_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_vertices.size() == 0) begin
            if (mismatches < 10) $display("unexpected vertex %h %h %h %b",
               rsp_out_x, rsp_out_y, rsp_out_z, rsp_unskinned);
            mismatches++;
         end else begin
            e = pending_vertices.pop_front();
            if (rsp_out_x !== e.x || rsp_out_y !== e.y || rsp_out_z !== e.z ||
                rsp_unskinned !== e.unskinned) begin
               if (mismatches < 10) $display(
                  "vertex mismatch: exp %h %h %h %b got %h %h %h %b",
                  e.x, e.y, e.z, e.unskinned,
                  rsp_out_x, rsp_out_y, rsp_out_z, rsp_unskinned);
               mismatches++;
            end
         end
      end
   end

   // Points with no joints pass unchanged, extremes included.
   task automatic test_passthrough();
      end_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0);
      end_vertex(32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff);
   endtask

   // Out-of-range writes mark nothing; identity and extreme bones skin.
   task automatic test_bone_table();
      send_item(ACT_WRITE, -1, 0, 32'h1234_5678, 0, 0, 0, 0);
      send_item(ACT_WRITE, 10, 12, 32'h1234_5678, 0, 0, 0, 0);
      send_item(ACT_WRITE, 10, 15, 32'hffff_ffff, 0, 0, 0, 0);
      load_bone(0, 1'b1);
      load_bone(255, 1'b0);
      add_joint(10, 24'hffffff);
      add_joint(0, 24'd1);
      end_vertex(32'h0003_0000, 32'hfffe_0000, 32'h7fff_ffff);
      add_joint(255, 24'hffffff);
      end_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0001_8000);
   endtask

   // Rejected, excess and ignored items.
   task automatic test_joint_rules();
      add_joint(-1, 24'd500);
      add_joint(0, 24'd0);
      end_vertex(32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
      add_joint(0, 24'h10000);
      add_joint(255, 24'h20000);
      add_joint(10, 24'h30000);
      add_joint(0, 24'hffffff);
      add_joint(255, 24'hffffff);
      send_item(ACT_NONE, 0, 0, $urandom, $urandom, $urandom, $urandom, $urandom);
      end_vertex(32'h0010_0000, 32'hfff0_0000, 32'h0000_0000);
   endtask

   // Mostly well-formed vertices with random content, plus loads and noise.
   task automatic test_random(input int items);
      int sent, k, n, pick;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            n = $urandom_range(255);
            load_bone(n, $urandom_range(3) == 0);
            sent += LBS_ELEMS;
         end else if (pick < 16) begin
            // Touch one element only of a loaded node, or miss the table.
            n = $urandom_range(255);
            if (bone_valid[n] && $urandom_range(1))
               send_item(ACT_WRITE, n, $urandom_range(11), pick32(), $urandom,
                         $urandom, $urandom, $urandom);
            else if ($urandom_range(1))
               send_item(ACT_WRITE, -$urandom_range(256, 1), $urandom, pick32(),
                         $urandom, $urandom, $urandom, $urandom);
            else
               send_item(ACT_WRITE, n, $urandom_range(15, 12), pick32(),
                         $urandom, $urandom, $urandom, $urandom);
         end else if (pick < 19) begin
            send_item(ACT_NONE, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
         end else begin
            k = $urandom_range(6);
            for (int j = 0; j < k; j++) begin
               case ($urandom_range(9))
                  0: add_joint(-$urandom_range(256, 1), pick_weight());
                  1: add_joint($urandom_range(255), 24'd0);
                  default: add_joint($urandom_range(255), pick_weight());
               endcase
            end
            end_vertex(pick32(), pick32(), pick32());
            sent += k + 1;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_WRITE;
      req_node = '0;
      req_slot = '0;
      req_elem_value = '0;
      req_weight = '0;
      req_point_x = '0;
      req_point_y = '0;
      req_point_z = '0;
      rsp_stall = 1'b0;
      mismatches = 0;
      joint_cnt = 0;
      weight_sum = '0;
      for (int i = 0; i < LBS_NUM_NODES; i++) bone_valid[i] = 1'b0;
      for (int k = 0; k < LBS_MAX_JOINTS; k++) begin
         joint_node_q[k] = '0;
         joint_weight_q[k] = '0;
      end
      send_idle_pct = 33;
      recv_idle_pct = 69;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_passthrough();
      test_bone_table();
      test_joint_rules();
      test_random(130);
      // Hold off until every vertex is out, then swap the idle mix.
      drain_vertices();
      send_idle_pct = 69;
      recv_idle_pct = 33;
      test_random(130);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(140);
      drain_vertices();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_vertices.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
